// ===== rtl/alg_pkg.sv =====
// ----------------------------------------------------------------------------
// Antialiased line generator package
// Shared types for the controller and the datapath.
// ----------------------------------------------------------------------------
package alg_pkg;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_FIRST  = 2'd1,
      PH_INNER  = 2'd2,
      PH_SECOND = 2'd3
   } phase_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic      load;       // capture a start word and set up the line
      logic      div_step;   // one restoring division step
      logic      div_finish; // apply sign and form the first accumulator
      logic      emit;       // build both pixel writes of the current column
      phase_type kind;       // which column is being emitted
      logic      advance;    // move the column and the accumulator on
   } alg_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_done;
      logic first_short;  // column + 1 >= column_end
      logic inner_end;    // column + 1 >= column_end, on the wrapped column
   } alg_sts_type;

endpackage

// ===== rtl/alg_datapath.sv =====
// ----------------------------------------------------------------------------
// Antialiased line datapath
// Endpoint set-up, serial gradient divider, row accumulator and pixel build.
// ----------------------------------------------------------------------------
module alg_datapath
   import alg_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 800,
   parameter int SCREEN_HEIGHT = 600,
   parameter int FRAC_BITS     = 16
) (
   input  logic              clock,
   input  logic [9:0]        x_start,
   input  logic [9:0]        y_start,
   input  logic [9:0]        x_finish,
   input  logic [9:0]        y_finish,
   input  logic [31:0]       line_color,
   input  alg_cmd_type       cmd,
   output alg_sts_type       sts,
   output logic [9:0]        pix_x     [2],
   output logic [9:0]        pix_y     [2],
   output logic [31:0]       pix_color [2],
   output logic              pix_in    [2]
);

   localparam int QW = 10 + FRAC_BITS;        // quotient width
   localparam int AW = 12 + FRAC_BITS;        // accumulator width
   localparam int CW = $clog2(QW + 1);
   localparam logic [AW-1:0] ONE = AW'(1) << FRAC_BITS;
   localparam logic [AW-1:0] HALF = AW'(1) << (FRAC_BITS - 1);

   logic          steep_ff;
   logic [9:0]    col_ff, col_end_ff, row1_ff, row2_ff;
   logic [31:0]   color_ff;
   logic [AW-1:0] acc_ff, slope_ff;
   logic          neg_ff, zero_ff;
   logic [QW-1:0] quo_ff;
   logic [10:0]   rem_ff;
   logic [9:0]    dx_ff;
   logic [CW-1:0] cnt_ff;

   logic [9:0]    ax0, ay0, ax1, ay1, sx0, sy0, sx1, sy1;
   logic [10:0]   adx, ady, trial;
   logic          steep;
   logic [QW-1:0] dividend;
   logic [AW-1:0] mag, slope_full;

   always_comb begin
      adx   = (x_finish >= x_start) ? 11'(x_finish - x_start) : 11'(x_start - x_finish);
      ady   = (y_finish >= y_start) ? 11'(y_finish - y_start) : 11'(y_start - y_finish);
      steep = ady > adx;
      ax0 = steep ? y_start : x_start;   ay0 = steep ? x_start : y_start;
      ax1 = steep ? y_finish : x_finish; ay1 = steep ? x_finish : y_finish;
      if (ax0 > ax1) begin
         sx0 = ax1; sy0 = ay1; sx1 = ax0; sy1 = ay0;
      end else begin
         sx0 = ax0; sy0 = ay0; sx1 = ax1; sy1 = ay1;
      end
      dividend = {(sy1 >= sy0) ? (sy1 - sy0) : (sy0 - sy1), {FRAC_BITS{1'b0}}};
      trial = {rem_ff[9:0], quo_ff[QW-1]} - {1'b0, dx_ff};
      mag   = zero_ff ? ONE : AW'(quo_ff);
      slope_full = neg_ff ? (AW'(0) - mag) : mag;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         steep_ff   <= steep;
         col_ff     <= sx0;
         col_end_ff <= sx1;
         row1_ff    <= sy0;
         row2_ff    <= sy1;
         color_ff   <= line_color;
         dx_ff      <= sx1 - sx0;
         zero_ff    <= (sx1 == sx0);
         neg_ff     <= sy1 < sy0;
         quo_ff     <= dividend;
         rem_ff     <= '0;
         cnt_ff     <= CW'(QW);
      end else if (cmd.div_step) begin
         if (!trial[10]) begin
            rem_ff <= trial;
            quo_ff <= {quo_ff[QW-2:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[9:0], quo_ff[QW-1]};
            quo_ff <= {quo_ff[QW-2:0], 1'b0};
         end
         cnt_ff <= cnt_ff - 1'b1;
      end else if (cmd.div_finish) begin
         slope_ff <= slope_full;
         acc_ff   <= {2'b00, row1_ff, {FRAC_BITS{1'b0}}} + slope_full;
      end else if (cmd.advance) begin
         if (cmd.kind == PH_INNER) begin
            acc_ff <= acc_ff + slope_ff;
            col_ff <= col_ff + 1'b1;
         end else if (cmd.kind == PH_FIRST) begin
            if (!sts.first_short) col_ff <= col_ff + 1'b1;
         end
      end
   end

   assign sts.div_done    = (cnt_ff == '0);
   assign sts.first_short = ({1'b0, col_ff} + 11'd1) >= {1'b0, col_end_ff};
   assign sts.inner_end   = (col_ff + 10'd1) >= col_end_ff;

   // Pixel build: both writes of a column are formed together and registered.
   logic [9:0]         col, row;
   logic [10:0]        rowp;
   logic [AW-1:0]      cov0, cov1;
   logic [FRAC_BITS:0] c0, c1;
   logic [9:0]         px [2], py [2];
   logic [10:0]        fx [2], fy [2];
   logic [FRAC_BITS+8:0] prod [2];
   logic [FRAC_BITS:0]   cv [2];

   always_comb begin
      col  = (cmd.kind == PH_SECOND) ? col_end_ff : col_ff;
      row  = row1_ff;
      cov0 = HALF;
      cov1 = '0;
      case (cmd.kind)
         PH_INNER: begin
            row  = acc_ff[FRAC_BITS+9:FRAC_BITS];
            cov1 = {{(AW-FRAC_BITS){1'b0}}, acc_ff[FRAC_BITS-1:0]};
            cov0 = ONE - cov1;
         end
         PH_SECOND: row = row2_ff;
         default: row = row1_ff;
      endcase
      rowp = {1'b0, row} + 11'd1;
      c0 = cov0[FRAC_BITS:0];
      c1 = cov1[FRAC_BITS:0];
      cv[0] = c0; cv[1] = c1;
      fy[0] = {1'b0, row}; fy[1] = rowp;
      for (int k = 0; k < 2; k++) begin
         px[k] = steep_ff ? fy[k][9:0] : col;
         py[k] = steep_ff ? col : fy[k][9:0];
         fx[k] = steep_ff ? fy[k] : {1'b0, col};
         prod[k] = color_ff[31:24] * cv[k];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         for (int k = 0; k < 2; k++) begin
            pix_x[k]     <= px[k];
            pix_y[k]     <= py[k];
            pix_color[k] <= {prod[k][FRAC_BITS+7:FRAC_BITS], color_ff[23:0]};
            pix_in[k]    <= (steep_ff ? (fx[k] < 11'(SCREEN_WIDTH)
                                         && {1'b0, col} < 11'(SCREEN_HEIGHT))
                                      : ({1'b0, col} < 11'(SCREEN_WIDTH)
                                         && fy[k] < 11'(SCREEN_HEIGHT)));
         end
      end
   end

endmodule

// ===== rtl/alg_controller.sv =====
// ----------------------------------------------------------------------------
// Antialiased line controller
// Sequences set-up, division, and the two writes of each step word.
// ----------------------------------------------------------------------------
module alg_controller
   import alg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_func,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_sel,
   output logic        rsp_last,
   output alg_cmd_type cmd,
   input  alg_sts_type sts
);

   typedef enum logic [2:0] {
      S_READY, S_DIV, S_FIN, S_OUT0, S_OUT1
   } state_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic      last_ff, last_in;
   logic      accept;

   assign req_stall = (state_ff != S_READY);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = (state_ff == S_OUT0) || (state_ff == S_OUT1);
   assign rsp_sel   = (state_ff == S_OUT1);
   assign rsp_last  = rsp_sel && last_ff;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      last_in  = last_ff;
      cmd      = '0;
      cmd.kind = phase_ff;
      case (state_ff)
         S_READY: begin
            if (accept) begin
               if (!req_func) begin
                  cmd.load = 1'b1;
                  state_in = S_DIV;
               end else if (phase_ff != PH_IDLE) begin
                  cmd.emit    = 1'b1;
                  cmd.advance = 1'b1;
                  last_in     = (phase_ff == PH_SECOND);
                  state_in    = S_OUT0;
                  case (phase_ff)
                     PH_FIRST:  phase_in = sts.first_short ? PH_SECOND : PH_INNER;
                     PH_INNER:  phase_in = sts.inner_end ? PH_SECOND : PH_INNER;
                     default:   phase_in = PH_IDLE;
                  endcase
               end
            end
         end
         S_DIV: begin
            if (sts.div_done) state_in = S_FIN;
            else cmd.div_step = 1'b1;
         end
         S_FIN: begin
            cmd.div_finish = 1'b1;
            phase_in       = PH_FIRST;
            state_in       = S_READY;
         end
         S_OUT0: if (!rsp_stall) state_in = S_OUT1;
         S_OUT1: if (!rsp_stall) state_in = S_READY;
         default: state_in = S_READY;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_READY;
         phase_ff <= PH_IDLE;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         last_ff  <= last_in;
      end
   end

endmodule

// ===== rtl/antialiased_line_generator_top.sv =====
// ----------------------------------------------------------------------------
// Antialiased line generator
// Wu line drawing: set-up with a serial gradient divider, two writes a step.
// ----------------------------------------------------------------------------
// Usage. A request word with func 0 starts a line from its endpoints and
// colour; it produces no response. The block then runs a restoring divider
// and a set-up state after it, and holds req_stall high throughout. A
// request word with func 1 produces the two pixel words of the next major
// column, the pixel at the smaller minor coordinate first; the last word of
// a line carries last. A step word while no line is active is taken and
// dropped. Each step word is captured and then answered with its two
// response words in turn, and the block takes no new request until both
// are taken. While rsp_stall is high the current response word is held
// unchanged and no new request is taken. A start word abandons any line in
// progress. Reset is synchronous and active high; it returns the block to
// idle with no line active, ready for a request on the next cycle.
// ----------------------------------------------------------------------------
module antialiased_line_generator_top
   import alg_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 800,
   parameter int SCREEN_HEIGHT = 600,
   parameter int FRAC_BITS     = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [9:0]  req_x_start,
   input  logic [9:0]  req_y_start,
   input  logic [9:0]  req_x_finish,
   input  logic [9:0]  req_y_finish,
   input  logic [31:0] req_line_color,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [9:0]  rsp_pixel_x,
   output logic [9:0]  rsp_pixel_y,
   output logic [31:0] rsp_pixel_color,
   output logic        rsp_in_screen,
   output logic        rsp_last
);

   alg_cmd_type cmd;
   alg_sts_type sts;
   logic        sel;
   logic [9:0]  pix_x [2];
   logic [9:0]  pix_y [2];
   logic [31:0] pix_color [2];
   logic        pix_in [2];

   // The controller owns the handshakes and the line phase; the datapath holds the rest of the line state.
   alg_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_sel   (sel),
      .rsp_last  (rsp_last),
      .cmd       (cmd),
      .sts       (sts)
   );

   alg_datapath #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .FRAC_BITS     (FRAC_BITS)
   ) u_dp (
      .clock      (clock),
      .x_start    (req_x_start),
      .y_start    (req_y_start),
      .x_finish   (req_x_finish),
      .y_finish   (req_y_finish),
      .line_color (req_line_color),
      .cmd        (cmd),
      .sts        (sts),
      .pix_x      (pix_x),
      .pix_y      (pix_y),
      .pix_color  (pix_color),
      .pix_in     (pix_in)
   );

   // Both words of a column are registered together; the select picks one.
   assign rsp_pixel_x     = pix_x[sel];
   assign rsp_pixel_y     = pix_y[sel];
   assign rsp_pixel_color = pix_color[sel];
   assign rsp_in_screen   = pix_in[sel];

endmodule
